/* design/mcas_pkg.sv */
`timescale 1ns / 1ps

package mcas_pkg;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CLEAR_MATE,
      OP_COLRED_FIRST,
      OP_COLRED,
      OP_WRITE_MATE,
      OP_SEARCH_INIT,
      OP_MARK_SEEN,
      OP_RELAX,
      OP_DUAL
   } cell_op_type;

   typedef enum logic [1:0] {
      KEY_OFF,
      KEY_COST,
      KEY_GREEDY,
      KEY_DIST
   } key_sel_type;

   typedef struct packed {
      cell_op_type op;
      key_sel_type key_sel;
   } cell_cmd_type;

   localparam int REQ_INDEX_WIDTH = 4;
   localparam int REQ_COST_WIDTH = 16;
   localparam int RSP_TOTAL_WIDTH = 20;
   localparam int SIZE_WIDTH = 5;
   localparam logic [SIZE_WIDTH-1:0] SIZE_RESET = 5'd16;

endpackage

/* design/mcas_if.sv */
`timescale 1ns / 1ps

interface mcas_req_if;
   logic valid;
   logic ready;
   logic [mcas_pkg::REQ_INDEX_WIDTH-1:0] row_index;
   logic [mcas_pkg::REQ_INDEX_WIDTH-1:0] column_index;
   logic signed [mcas_pkg::REQ_COST_WIDTH-1:0] entry_cost;
   logic last_entry;

   modport source (output valid, row_index, column_index, entry_cost, last_entry,
                   input ready);
   modport sink (input valid, row_index, column_index, entry_cost, last_entry,
                 output ready);
endinterface

interface mcas_rsp_if;
   logic valid;
   logic ready;
   logic [mcas_pkg::REQ_INDEX_WIDTH-1:0] result_row;
   logic [mcas_pkg::REQ_INDEX_WIDTH-1:0] mate_column;
   logic signed [mcas_pkg::RSP_TOTAL_WIDTH-1:0] total_cost;
   logic last_result;

   modport source (output valid, result_row, mate_column, total_cost, last_result,
                   input ready);
   modport sink (input valid, result_row, mate_column, total_cost, last_result,
                 output ready);
endinterface

/* design/min_cost_assignment_solver_core.sv */
`timescale 1ns / 1ps
// Square minimum-cost assignment solver.
// The request channel loads cost entries, one per cycle, each with its row and
// column; entries outside the array are dropped. A request with last_entry set
// is stored and then starts the solve on the leading n-by-n block, n taken from
// the size register (csr_write_enable / csr_write_data, reset value 16).
// While a solve runs and its results are reported, req ready stays low.
// The solve runs in a row of one cell per column. Every minimum over columns
// travels along that row, one cell per cycle, so each row reduction, greedy
// step and search step waits for it to reach the end of the row. A full solve
// runs the row and column reductions and the greedy matching, then one
// augmenting path per row still unmatched, and finally sums the total.
// Results follow, one per row in row order; a stalled receiver simply holds
// the current result in the output register.
// Synchronous reset returns the block to idle, clears the valid, seen, mate and
// row-done flags and sets the size register to 16; the cost store keeps whatever it held.

module min_cost_assignment_solver_core #(
   parameter int MAX_SIZE = 16,
   parameter int COST_WIDTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   mcas_req_if.sink                           req_chan,
   mcas_rsp_if.source                         rsp_chan,
   input  logic                               csr_write_enable,
   input  logic [mcas_pkg::SIZE_WIDTH-1:0]    csr_write_data
);

   localparam int AW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
   localparam int NW = $clog2(MAX_SIZE + 1);
   localparam int VW = COST_WIDTH + $clog2(MAX_SIZE) + 4;
   localparam int WTW = $clog2(MAX_SIZE + 2);
   localparam logic [WTW-1:0] WAIT_CHAIN = WTW'(MAX_SIZE + 1);
   localparam int IW = mcas_pkg::REQ_INDEX_WIDTH;
   localparam int TW = mcas_pkg::RSP_TOTAL_WIDTH;

   typedef enum logic [4:0] {
      ST_IDLE, ST_WAIT, ST_RR_SET, ST_RR_DO, ST_CR_SET, ST_CR_DO, ST_GR_SET,
      ST_GR_DO, ST_LOOP, ST_SI_SET, ST_SI_DO, ST_FIND_SET, ST_FIND_DO,
      ST_RELAX_SET, ST_RELAX_DO, ST_DUAL, ST_DU_CHK, ST_DU_WR, ST_US_SET,
      ST_US_WR, ST_FLIP, ST_TOT_SET, ST_TOT_DO, ST_OUT_SET, ST_OUT_LOAD,
      ST_OUT_HOLD
   } state_type;

   state_type state_ff, state_in, ret_ff, ret_in;
   logic [WTW-1:0] wait_ff, wait_in;
   logic [mcas_pkg::SIZE_WIDTH-1:0] size_ff;
   logic [NW-1:0] n_ff, n_in;
   logic [NW-1:0] i_ff, i_in;
   logic [NW-1:0] matched_ff, matched_in;
   logic [AW-1:0] row_addr_ff, row_addr_in;
   mcas_pkg::key_sel_type key_sel_ff, key_sel_in;
   logic [AW-1:0] s_ff, s_in;
   logic [AW-1:0] j_ff, j_in;
   logic signed [VW-1:0] dj_ff, dj_in;
   logic signed [VW-1:0] delta_ff, delta_in;
   logic [MAX_SIZE-1:0] row_done_ff, row_done_in;
   logic signed [VW-1:0] total_ff, total_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [IW-1:0] rsp_row_ff, rsp_row_in;
   logic [IW-1:0] rsp_mate_ff, rsp_mate_in;
   logic [TW-1:0] rsp_total_ff, rsp_total_in;
   logic rsp_last_ff, rsp_last_in;

   mcas_pkg::cell_cmd_type cmd;
   logic [AW-1:0] jbc;
   logic mate_bc_valid;
   logic [AW-1:0] mate_bc;
   logic u_we;
   logic [VW-1:0] u_wdata, u_rdata;
   logic signed [VW-1:0] ubc;
   logic lm_we;
   logic [AW-1:0] lm_addr, lm_wdata, lm_rdata;

   logic req_accept;
   logic [AW+IW-1:0] wr_row_ext;
   logic [AW-1:0] wr_addr;
   logic [COST_WIDTH+mcas_pkg::REQ_COST_WIDTH-1:0] cost_ext;
   logic [COST_WIDTH-1:0] wr_data;
   logic row_in_range;

   logic tv [MAX_SIZE+1];
   logic signed [VW-1:0] tk [MAX_SIZE+1];
   logic [AW-1:0] ti [MAX_SIZE+1];
   logic trv [MAX_SIZE+1];
   logic [AW-1:0] trm [MAX_SIZE+1];

   logic [COST_WIDTH-1:0] cell_cost [MAX_SIZE];
   logic signed [VW-1:0] cell_dist [MAX_SIZE];
   logic cell_seen [MAX_SIZE];
   logic cell_rmv [MAX_SIZE];
   logic [AW-1:0] cell_rm [MAX_SIZE];
   logic cell_pv [MAX_SIZE];
   logic [AW-1:0] cell_par [MAX_SIZE];

   logic [6:0] size_ext;
   logic [AW-1:0] s_low;
   logic [AW-1:0] ia;
   logic [AW-1:0] pd;
   logic [COST_WIDTH-1:0] sel_cost;
   logic signed [VW-1:0] sel_cost_s;
   logic [NW+IW-1:0] i_ext;
   logic [AW+IW-1:0] mate_ext;
   logic [VW+TW-1:0] total_ext;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_accept = req_chan.valid && req_chan.ready;

   assign wr_row_ext = {{AW{1'b0}}, req_chan.row_index};
   assign wr_addr = wr_row_ext[AW-1:0];
   assign cost_ext = {{COST_WIDTH{1'b0}}, req_chan.entry_cost};
   assign wr_data = cost_ext[COST_WIDTH-1:0];
   assign row_in_range = 7'(req_chan.row_index) < 7'(MAX_SIZE);

   assign ubc = u_rdata;

   assign tv[0] = 1'b0;
   assign tk[0] = '0;
   assign ti[0] = '0;
   assign trv[0] = 1'b0;
   assign trm[0] = '0;

   for (genvar k = 0; k < MAX_SIZE; k++) begin : g_cell
      logic wr_en;
      assign wr_en = req_accept && row_in_range &&
                     (7'(req_chan.column_index) == 7'(k));
      mcas_cell #(.MAX_SIZE(MAX_SIZE), .COST_WIDTH(COST_WIDTH), .IDX(k)) u_cell (
         .clock            (clock),
         .reset            (reset),
         .cmd              (cmd),
         .n                (n_ff),
         .row_addr         (row_addr_ff),
         .wr_en            (wr_en),
         .wr_addr          (wr_addr),
         .wr_data          (wr_data),
         .ubc              (ubc),
         .dbc              (dj_ff),
         .jbc              (jbc),
         .mate_bc_valid    (mate_bc_valid),
         .mate_bc          (mate_bc),
         .tok_in_valid     (tv[k]),
         .tok_in_key       (tk[k]),
         .tok_in_idx       (ti[k]),
         .tok_in_rm_valid  (trv[k]),
         .tok_in_rm        (trm[k]),
         .tok_out_valid    (tv[k+1]),
         .tok_out_key      (tk[k+1]),
         .tok_out_idx      (ti[k+1]),
         .tok_out_rm_valid (trv[k+1]),
         .tok_out_rm       (trm[k+1]),
         .cost_out         (cell_cost[k]),
         .dist_out         (cell_dist[k]),
         .seen_out         (cell_seen[k]),
         .rm_valid_out     (cell_rmv[k]),
         .rm_out           (cell_rm[k]),
         .parent_valid_out (cell_pv[k]),
         .parent_out       (cell_par[k])
      );
   end

   mcas_ram #(.WIDTH(VW), .DEPTH(MAX_SIZE)) u_row_pot_ram (
      .clock (clock),
      .we    (u_we),
      .addr  (row_addr_ff),
      .wdata (u_wdata),
      .rdata (u_rdata)
   );

   mcas_ram #(.WIDTH(AW), .DEPTH(MAX_SIZE)) u_left_mate_ram (
      .clock (clock),
      .we    (lm_we),
      .addr  (lm_addr),
      .wdata (lm_wdata),
      .rdata (lm_rdata)
   );

   always_comb begin
      s_low = '0;
      for (int k = MAX_SIZE - 1; k >= 0; k--) begin
         if (!row_done_ff[k] && NW'(k) < n_ff) begin
            s_low = AW'(k);
         end
      end
   end

   assign size_ext = {2'b00, size_ff};
   assign ia = i_ff[AW-1:0];
   assign pd = cell_par[j_ff];
   assign sel_cost = cell_cost[lm_rdata];
   assign sel_cost_s = {{(VW - COST_WIDTH){sel_cost[COST_WIDTH-1]}}, sel_cost};
   assign i_ext = {{IW{1'b0}}, i_ff};
   assign mate_ext = {{IW{1'b0}}, lm_rdata};
   assign total_ext = {{TW{total_ff[VW-1]}}, total_ff};

   always_comb begin
      state_in = state_ff;
      ret_in = ret_ff;
      wait_in = wait_ff;
      n_in = n_ff;
      i_in = i_ff;
      matched_in = matched_ff;
      row_addr_in = row_addr_ff;
      key_sel_in = key_sel_ff;
      s_in = s_ff;
      j_in = j_ff;
      dj_in = dj_ff;
      delta_in = delta_ff;
      row_done_in = row_done_ff;
      total_in = total_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_row_in = rsp_row_ff;
      rsp_mate_in = rsp_mate_ff;
      rsp_total_in = rsp_total_ff;
      rsp_last_in = rsp_last_ff;
      cmd.op = mcas_pkg::OP_NONE;
      cmd.key_sel = key_sel_ff;
      jbc = j_ff;
      mate_bc_valid = 1'b1;
      mate_bc = s_ff;
      u_we = 1'b0;
      u_wdata = tk[MAX_SIZE];
      lm_we = 1'b0;
      lm_addr = row_addr_ff;
      lm_wdata = j_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_chan.last_entry) begin
               if (size_ext == 7'd0) begin
                  n_in = NW'(1);
               end else if (size_ext > 7'(MAX_SIZE)) begin
                  n_in = NW'(MAX_SIZE);
               end else begin
                  n_in = NW'(size_ext);
               end
               cmd.op = mcas_pkg::OP_CLEAR_MATE;
               i_in = '0;
               matched_in = '0;
               row_done_in = '0;
               total_in = '0;
               state_in = ST_RR_SET;
            end
         end
         ST_WAIT: begin
            if (wait_ff == '0) begin
               state_in = ret_ff;
            end else begin
               wait_in = wait_ff - 1'b1;
            end
         end
         ST_RR_SET: begin
            row_addr_in = ia;
            key_sel_in = mcas_pkg::KEY_COST;
            wait_in = WAIT_CHAIN;
            ret_in = ST_RR_DO;
            state_in = ST_WAIT;
         end
         ST_RR_DO: begin
            u_we = 1'b1;
            u_wdata = tk[MAX_SIZE];
            if (i_ff + 1'b1 == n_ff) begin
               i_in = '0;
               state_in = ST_CR_SET;
            end else begin
               i_in = i_ff + 1'b1;
               state_in = ST_RR_SET;
            end
         end
         ST_CR_SET: begin
            row_addr_in = ia;
            key_sel_in = mcas_pkg::KEY_OFF;
            wait_in = '0;
            ret_in = ST_CR_DO;
            state_in = ST_WAIT;
         end
         ST_CR_DO: begin
            cmd.op = (i_ff == '0) ? mcas_pkg::OP_COLRED_FIRST : mcas_pkg::OP_COLRED;
            if (i_ff + 1'b1 == n_ff) begin
               i_in = '0;
               state_in = ST_GR_SET;
            end else begin
               i_in = i_ff + 1'b1;
               state_in = ST_CR_SET;
            end
         end
         ST_GR_SET: begin
            row_addr_in = ia;
            key_sel_in = mcas_pkg::KEY_GREEDY;
            wait_in = WAIT_CHAIN;
            ret_in = ST_GR_DO;
            state_in = ST_WAIT;
         end
         ST_GR_DO: begin
            if (tv[MAX_SIZE]) begin
               cmd.op = mcas_pkg::OP_WRITE_MATE;
               jbc = ti[MAX_SIZE];
               mate_bc = ia;
               lm_we = 1'b1;
               lm_wdata = ti[MAX_SIZE];
               row_done_in[ia] = 1'b1;
               matched_in = matched_ff + 1'b1;
            end
            if (i_ff + 1'b1 == n_ff) begin
               state_in = ST_LOOP;
            end else begin
               i_in = i_ff + 1'b1;
               state_in = ST_GR_SET;
            end
         end
         ST_LOOP: begin
            if (matched_ff == n_ff) begin
               i_in = '0;
               state_in = ST_TOT_SET;
            end else begin
               s_in = s_low;
               state_in = ST_SI_SET;
            end
         end
         ST_SI_SET: begin
            row_addr_in = s_ff;
            key_sel_in = mcas_pkg::KEY_OFF;
            wait_in = '0;
            ret_in = ST_SI_DO;
            state_in = ST_WAIT;
         end
         ST_SI_DO: begin
            cmd.op = mcas_pkg::OP_SEARCH_INIT;
            state_in = ST_FIND_SET;
         end
         ST_FIND_SET: begin
            key_sel_in = mcas_pkg::KEY_DIST;
            wait_in = WAIT_CHAIN;
            ret_in = ST_FIND_DO;
            state_in = ST_WAIT;
         end
         ST_FIND_DO: begin
            if (!tv[MAX_SIZE]) begin
               // No reachable column is left: report what is matched so far.
               i_in = '0;
               state_in = ST_TOT_SET;
            end else begin
               cmd.op = mcas_pkg::OP_MARK_SEEN;
               jbc = ti[MAX_SIZE];
               j_in = ti[MAX_SIZE];
               dj_in = tk[MAX_SIZE];
               if (trv[MAX_SIZE]) begin
                  row_addr_in = trm[MAX_SIZE];
                  state_in = ST_RELAX_SET;
               end else begin
                  state_in = ST_DUAL;
               end
            end
         end
         ST_RELAX_SET: begin
            key_sel_in = mcas_pkg::KEY_OFF;
            wait_in = '0;
            ret_in = ST_RELAX_DO;
            state_in = ST_WAIT;
         end
         ST_RELAX_DO: begin
            cmd.op = mcas_pkg::OP_RELAX;
            state_in = ST_FIND_SET;
         end
         ST_DUAL: begin
            cmd.op = mcas_pkg::OP_DUAL;
            key_sel_in = mcas_pkg::KEY_OFF;
            i_in = '0;
            state_in = ST_DU_CHK;
         end
         ST_DU_CHK: begin
            if (i_ff == n_ff) begin
               state_in = ST_US_SET;
            end else if (ia != j_ff && cell_seen[ia] && cell_rmv[ia]) begin
               row_addr_in = cell_rm[ia];
               delta_in = cell_dist[ia] - dj_ff;
               wait_in = '0;
               ret_in = ST_DU_WR;
               state_in = ST_WAIT;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         ST_DU_WR: begin
            u_we = 1'b1;
            u_wdata = ubc - delta_ff;
            i_in = i_ff + 1'b1;
            state_in = ST_DU_CHK;
         end
         ST_US_SET: begin
            row_addr_in = s_ff;
            wait_in = '0;
            ret_in = ST_US_WR;
            state_in = ST_WAIT;
         end
         ST_US_WR: begin
            u_we = 1'b1;
            u_wdata = ubc + dj_ff;
            state_in = ST_FLIP;
         end
         ST_FLIP: begin
            cmd.op = mcas_pkg::OP_WRITE_MATE;
            jbc = j_ff;
            lm_wdata = j_ff;
            if (cell_pv[j_ff]) begin
               // Walk back along the search tree, shifting each row one column on.
               mate_bc_valid = cell_rmv[pd];
               mate_bc = cell_rm[pd];
               lm_we = cell_rmv[pd];
               lm_addr = cell_rm[pd];
               j_in = pd;
            end else begin
               mate_bc = s_ff;
               lm_we = 1'b1;
               lm_addr = s_ff;
               row_done_in[s_ff] = 1'b1;
               matched_in = matched_ff + 1'b1;
               state_in = ST_LOOP;
            end
         end
         ST_TOT_SET: begin
            row_addr_in = ia;
            key_sel_in = mcas_pkg::KEY_OFF;
            wait_in = '0;
            ret_in = ST_TOT_DO;
            state_in = ST_WAIT;
         end
         ST_TOT_DO: begin
            if (row_done_ff[ia]) begin
               total_in = total_ff + sel_cost_s;
            end
            if (i_ff + 1'b1 == n_ff) begin
               i_in = '0;
               state_in = ST_OUT_SET;
            end else begin
               i_in = i_ff + 1'b1;
               state_in = ST_TOT_SET;
            end
         end
         ST_OUT_SET: begin
            row_addr_in = ia;
            wait_in = '0;
            ret_in = ST_OUT_LOAD;
            state_in = ST_WAIT;
         end
         ST_OUT_LOAD: begin
            rsp_valid_in = 1'b1;
            rsp_row_in = i_ext[IW-1:0];
            rsp_mate_in = row_done_ff[ia] ? mate_ext[IW-1:0] : '0;
            rsp_total_in = total_ext[TW-1:0];
            rsp_last_in = (i_ff + 1'b1 == n_ff);
            state_in = ST_OUT_HOLD;
         end
         ST_OUT_HOLD: begin
            if (rsp_chan.ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  i_in = i_ff + 1'b1;
                  state_in = ST_OUT_SET;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff <= ST_IDLE;
         wait_ff <= '0;
         size_ff <= mcas_pkg::SIZE_RESET;
         matched_ff <= '0;
         row_done_ff <= '0;
         key_sel_ff <= mcas_pkg::KEY_OFF;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff <= ret_in;
         wait_ff <= wait_in;
         if (csr_write_enable) begin
            size_ff <= csr_write_data;
         end
         matched_ff <= matched_in;
         row_done_ff <= row_done_in;
         key_sel_ff <= key_sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff <= n_in;
      i_ff <= i_in;
      row_addr_ff <= row_addr_in;
      s_ff <= s_in;
      j_ff <= j_in;
      dj_ff <= dj_in;
      delta_ff <= delta_in;
      total_ff <= total_in;
      rsp_row_ff <= rsp_row_in;
      rsp_mate_ff <= rsp_mate_in;
      rsp_total_ff <= rsp_total_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.result_row = rsp_row_ff;
   assign rsp_chan.mate_column = rsp_mate_ff;
   assign rsp_chan.total_cost = rsp_total_ff;
   assign rsp_chan.last_result = rsp_last_ff;

endmodule

/* design/mcas_ram.sv */
`timescale 1ns / 1ps

module mcas_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

/* design/mcas_cell.sv */
`timescale 1ns / 1ps

module mcas_cell #(
   parameter int MAX_SIZE = 16,
   parameter int COST_WIDTH = 16,
   parameter int IDX = 0,
   localparam int AW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1,
   localparam int NW = $clog2(MAX_SIZE + 1),
   localparam int VW = COST_WIDTH + $clog2(MAX_SIZE) + 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  mcas_pkg::cell_cmd_type  cmd,
   input  logic [NW-1:0]           n,
   input  logic [AW-1:0]           row_addr,
   input  logic                    wr_en,
   input  logic [AW-1:0]           wr_addr,
   input  logic [COST_WIDTH-1:0]   wr_data,
   input  logic signed [VW-1:0]    ubc,
   input  logic signed [VW-1:0]    dbc,
   input  logic [AW-1:0]           jbc,
   input  logic                    mate_bc_valid,
   input  logic [AW-1:0]           mate_bc,
   input  logic                    tok_in_valid,
   input  logic signed [VW-1:0]    tok_in_key,
   input  logic [AW-1:0]           tok_in_idx,
   input  logic                    tok_in_rm_valid,
   input  logic [AW-1:0]           tok_in_rm,
   output logic                    tok_out_valid,
   output logic signed [VW-1:0]    tok_out_key,
   output logic [AW-1:0]           tok_out_idx,
   output logic                    tok_out_rm_valid,
   output logic [AW-1:0]           tok_out_rm,
   output logic [COST_WIDTH-1:0]   cost_out,
   output logic signed [VW-1:0]    dist_out,
   output logic                    seen_out,
   output logic                    rm_valid_out,
   output logic [AW-1:0]           rm_out,
   output logic                    parent_valid_out,
   output logic [AW-1:0]           parent_out
);

   localparam logic [AW-1:0] MY_IDX = AW'(IDX);

   logic [COST_WIDTH-1:0] cost;
   logic signed [VW-1:0] cost_s;
   logic active;

   logic signed [VW-1:0] v_ff, v_in;
   logic signed [VW-1:0] dist_ff, dist_in;
   logic seen_ff, seen_in;
   logic rm_valid_ff, rm_valid_in;
   logic [AW-1:0] rm_ff, rm_in;
   logic parent_valid_ff, parent_valid_in;
   logic [AW-1:0] parent_ff, parent_in;
   logic tok_valid_ff, tok_valid_in;
   logic signed [VW-1:0] tok_key_ff, tok_key_in;
   logic [AW-1:0] tok_idx_ff, tok_idx_in;
   logic tok_rm_valid_ff, tok_rm_valid_in;
   logic [AW-1:0] tok_rm_ff, tok_rm_in;

   logic signed [VW-1:0] reduced;
   logic signed [VW-1:0] relaxed;
   logic key_en;
   logic signed [VW-1:0] key;

   mcas_ram #(.WIDTH(COST_WIDTH), .DEPTH(MAX_SIZE)) u_cost_ram (
      .clock (clock),
      .we    (wr_en),
      .addr  (wr_en ? wr_addr : row_addr),
      .wdata (wr_data),
      .rdata (cost)
   );

   assign cost_s = {{(VW - COST_WIDTH){cost[COST_WIDTH-1]}}, cost};
   assign active = NW'(IDX) < n;
   assign reduced = cost_s - ubc - v_ff;
   assign relaxed = dbc + reduced;

   always_comb begin
      key_en = 1'b0;
      key = '0;
      case (cmd.key_sel)
         mcas_pkg::KEY_COST: begin
            key_en = active;
            key = cost_s;
         end
         mcas_pkg::KEY_GREEDY: begin
            key_en = active && !rm_valid_ff && (cost_s == ubc + v_ff);
         end
         mcas_pkg::KEY_DIST: begin
            key_en = active && !seen_ff;
            key = dist_ff;
         end
         default: begin
            key_en = 1'b0;
         end
      endcase
   end

   // The running minimum moves one cell per cycle; on a tie the lower column,
   // which arrives from the left, is kept.
   always_comb begin
      if (key_en && (!tok_in_valid || key < tok_in_key)) begin
         tok_valid_in = 1'b1;
         tok_key_in = key;
         tok_idx_in = MY_IDX;
         tok_rm_valid_in = rm_valid_ff;
         tok_rm_in = rm_ff;
      end else begin
         tok_valid_in = tok_in_valid;
         tok_key_in = tok_in_key;
         tok_idx_in = tok_in_idx;
         tok_rm_valid_in = tok_in_rm_valid;
         tok_rm_in = tok_in_rm;
      end
   end

   always_comb begin
      v_in = v_ff;
      dist_in = dist_ff;
      seen_in = seen_ff;
      rm_valid_in = rm_valid_ff;
      rm_in = rm_ff;
      parent_valid_in = parent_valid_ff;
      parent_in = parent_ff;
      case (cmd.op)
         mcas_pkg::OP_CLEAR_MATE: begin
            rm_valid_in = 1'b0;
         end
         mcas_pkg::OP_COLRED_FIRST: begin
            v_in = cost_s - ubc;
         end
         mcas_pkg::OP_COLRED: begin
            if (cost_s - ubc < v_ff) begin
               v_in = cost_s - ubc;
            end
         end
         mcas_pkg::OP_WRITE_MATE: begin
            if (jbc == MY_IDX) begin
               rm_valid_in = mate_bc_valid;
               rm_in = mate_bc;
            end
         end
         mcas_pkg::OP_SEARCH_INIT: begin
            parent_valid_in = 1'b0;
            seen_in = 1'b0;
            dist_in = reduced;
         end
         mcas_pkg::OP_MARK_SEEN: begin
            if (jbc == MY_IDX) begin
               seen_in = 1'b1;
            end
         end
         mcas_pkg::OP_RELAX: begin
            if (active && !seen_ff && dist_ff > relaxed) begin
               dist_in = relaxed;
               parent_valid_in = 1'b1;
               parent_in = jbc;
            end
         end
         mcas_pkg::OP_DUAL: begin
            if (jbc != MY_IDX && seen_ff && rm_valid_ff) begin
               v_in = v_ff + dist_ff - dbc;
            end
         end
         default: begin
            v_in = v_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
         rm_valid_ff <= 1'b0;
         parent_valid_ff <= 1'b0;
         tok_valid_ff <= 1'b0;
      end else begin
         seen_ff <= seen_in;
         rm_valid_ff <= rm_valid_in;
         parent_valid_ff <= parent_valid_in;
         tok_valid_ff <= tok_valid_in;
      end
      v_ff <= v_in;
      dist_ff <= dist_in;
      rm_ff <= rm_in;
      parent_ff <= parent_in;
      tok_key_ff <= tok_key_in;
      tok_idx_ff <= tok_idx_in;
      tok_rm_valid_ff <= tok_rm_valid_in;
      tok_rm_ff <= tok_rm_in;
   end

   assign tok_out_valid = tok_valid_ff;
   assign tok_out_key = tok_key_ff;
   assign tok_out_idx = tok_idx_ff;
   assign tok_out_rm_valid = tok_rm_valid_ff;
   assign tok_out_rm = tok_rm_ff;
   assign cost_out = cost;
   assign dist_out = dist_ff;
   assign seen_out = seen_ff;
   assign rm_valid_out = rm_valid_ff;
   assign rm_out = rm_ff;
   assign parent_valid_out = parent_valid_ff;
   assign parent_out = parent_ff;

endmodule

/* design/mcas_checker.sv */
`timescale 1ns / 1ps

module mcas_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_last
);

   // A result that is not taken stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // New requests are taken only while no result is pending.
   assert property (@(posedge clock) req_ready |-> !rsp_valid)
      else $error("request accepted while a result is pending");

   // The final result of a solve returns the block to idle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> !rsp_valid && req_ready)
      else $error("block did not return to idle after the final result");

   // Reset leaves the block idle and ready for a new request.
   assert property (@(posedge clock) reset |=> req_ready && !rsp_valid)
      else $error("block not idle after reset");

endmodule

bind min_cost_assignment_solver_core mcas_checker u_mcas_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_last  (rsp_chan.last_result)
);

/* tb/sv/mcas_tb_if.sv */
`timescale 1ns / 1ps

// Testbench copy of the channel interfaces is not needed; the design's own
// interfaces are used. This file holds the checker.
module mcas_assignment_checker (
   input  logic clock,
   input  logic reset,
   mcas_req_if.sink req_mon,
   mcas_rsp_if.sink rsp_mon,
   input  logic csr_write_enable,
   input  logic [mcas_pkg::SIZE_WIDTH-1:0] csr_write_data,
   output int   failure_count,
   output int   pending_count,
   output int   solve_count
);
   typedef struct packed {
      logic [3:0]  result_row;
      logic [3:0]  mate_column;
      logic [19:0] total_cost;
      logic        last_result;
   } assignment_type;

   longint cost_matrix [16][16];
   int unsigned size_setting;
   assignment_type expected_assignments[$];

   // Hungarian method with row and column duals; ties go to the lowest column.
   task automatic solve_assignment(input int n);
      longint row_pot[16], col_pot[16], path_dist[16], d, total;
      int parent[16], lmate[16], rmate[16];
      bit seen[16];
      int matched, s, j, r, k, p;
      assignment_type a;
      total = 0;
      for (int i = 0; i < n; i++) begin
         row_pot[i] = cost_matrix[i][0];
         for (int c = 1; c < n; c++)
            if (cost_matrix[i][c] < row_pot[i]) row_pot[i] = cost_matrix[i][c];
      end
      for (int c = 0; c < n; c++) begin
         col_pot[c] = cost_matrix[0][c] - row_pot[0];
         for (int i = 1; i < n; i++)
            if (cost_matrix[i][c] - row_pot[i] < col_pot[c])
               col_pot[c] = cost_matrix[i][c] - row_pot[i];
      end
      for (int i = 0; i < 16; i++) begin
         lmate[i] = -1;
         rmate[i] = -1;
      end
      matched = 0;
      for (int i = 0; i < n; i++)
         for (int c = 0; c < n; c++)
            if (rmate[c] == -1 && cost_matrix[i][c] == row_pot[i] + col_pot[c]) begin
               lmate[i] = c;
               rmate[c] = i;
               matched++;
               break;
            end
      while (matched < n) begin
         s = 0;
         while (s < n - 1 && lmate[s] != -1) s++;
         for (k = 0; k < 16; k++) begin
            parent[k] = -1;
            seen[k] = 0;
         end
         for (k = 0; k < n; k++)
            path_dist[k] = cost_matrix[s][k] - row_pot[s] - col_pot[k];
         forever begin
            j = -1;
            for (k = 0; k < n; k++)
               if (!seen[k] && (j == -1 || path_dist[k] < path_dist[j])) j = k;
            if (j == -1) break;
            seen[j] = 1;
            if (rmate[j] == -1) break;
            r = rmate[j];
            for (k = 0; k < n; k++)
               if (!seen[k]) begin
                  d = path_dist[j] + cost_matrix[r][k] - row_pot[r] - col_pot[k];
                  if (path_dist[k] > d) begin
                     path_dist[k] = d;
                     parent[k] = j;
                  end
               end
         end
         if (j == -1) break;
         for (k = 0; k < n; k++)
            if (k != j && seen[k] && rmate[k] != -1) begin
               col_pot[k] += path_dist[k] - path_dist[j];
               row_pot[rmate[k]] -= path_dist[k] - path_dist[j];
            end
         row_pot[s] += path_dist[j];
         while (parent[j] != -1) begin
            p = parent[j];
            rmate[j] = rmate[p];
            if (rmate[j] != -1) lmate[rmate[j]] = j;
            j = p;
         end
         rmate[j] = s;
         lmate[s] = j;
         matched++;
      end
      for (int i = 0; i < n; i++)
         if (lmate[i] != -1) total += cost_matrix[i][lmate[i]];
      for (int i = 0; i < n; i++) begin
         a.result_row = i[3:0];
         a.mate_column = (lmate[i] < 0) ? 4'd0 : lmate[i][3:0];
         a.total_cost = total[19:0];
         a.last_result = (i == n - 1);
         expected_assignments.push_back(a);
      end
   endtask

   always @(posedge clock) begin
      int n;
      assignment_type got, want;
      if (reset) begin
         size_setting = 16;
         failure_count <= 0;
         solve_count <= 0;
      end else begin
         if (csr_write_enable) size_setting = csr_write_data;
         if (req_mon.valid && req_mon.ready) begin
            cost_matrix[req_mon.row_index][req_mon.column_index] = req_mon.entry_cost;
            if (req_mon.last_entry) begin
               n = size_setting;
               if (n < 1) n = 1;
               if (n > 16) n = 16;
               solve_assignment(n);
               solve_count <= solve_count + 1;
            end
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = {rsp_mon.result_row, rsp_mon.mate_column, rsp_mon.total_cost,
                   rsp_mon.last_result};
            if (expected_assignments.size() == 0) begin
               $display("%0t: unexpected result: row %0d column %0d total %0d",
                        $time, got.result_row, got.mate_column, $signed(got.total_cost));
               failure_count <= failure_count + 1;
            end else begin
               want = expected_assignments.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch: expected row %0d col %0d total %0d last %0b",
                           $time, want.result_row, want.mate_column,
                           $signed(want.total_cost), want.last_result);
                  $display("%0t:           actual row %0d col %0d total %0d last %0b",
                           $time, got.result_row, got.mate_column,
                           $signed(got.total_cost), got.last_result);
                  failure_count <= failure_count + 1;
               end
            end
         end
      end
      pending_count <= expected_assignments.size();
   end
endmodule

/* tb/sv/min_cost_assignment_solver_core_test.sv */
`timescale 1ns / 1ps

module min_cost_assignment_solver_core_test;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [mcas_pkg::SIZE_WIDTH-1:0] csr_write_data;
   int failure_count, pending_count, solve_count;
   int entries_sent;
   int current_size;
   bit done;

   mcas_req_if req_chan ();
   mcas_rsp_if rsp_chan ();

   min_cost_assignment_solver_core DUT (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   mcas_assignment_checker checker_inst (
      .clock(clock),
      .reset(reset),
      .req_mon(req_chan),
      .rsp_mon(rsp_chan),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .failure_count(failure_count),
      .pending_count(pending_count),
      .solve_count(solve_count)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Receiver stalls on its own pattern: long open stretches and random stalls.
   initial begin
      int phase;
      rsp_chan.ready = 0;
      phase = 0;
      forever begin
         @(posedge clock);
         phase++;
         if ((phase / 200) % 3 == 0) rsp_chan.ready <= 1'b1;
         else rsp_chan.ready <= ($urandom_range(0, 3) != 0);
      end
   end

   // Sender gap control: bursts of random length, then random gaps.
   int burst_left;
   int gap_left;

   task automatic send_request(input int r, input int c,
                               input logic [15:0] cost, input logic last);
      if (gap_left > 0) req_chan.valid <= 1'b0;
      while (gap_left > 0) begin
         gap_left--;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.row_index <= 4'(r);
      req_chan.column_index <= 4'(c);
      req_chan.entry_cost <= cost;
      req_chan.last_entry <= last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      entries_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 12);
         gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
      end
   endtask

   task automatic drain_results();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_size(input int value);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_write_data <= value[mcas_pkg::SIZE_WIDTH-1:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      if (value < 1) current_size = 1;
      else if (value > 16) current_size = 16;
      else current_size = value;
   endtask

   function automatic logic [15:0] pick_cost(input int style);
      case (style)
         0: pick_cost = 16'($urandom_range(0, 15));
         1: pick_cost = 16'h8000 + 16'($urandom_range(0, 3));
         2: pick_cost = 16'h7FFF - 16'($urandom_range(0, 3));
         default: pick_cost = 16'($urandom);
      endcase
   endfunction

   // Loads the whole leading block in random order, the last entry starting the solve.
   task automatic load_matrix(input int style);
      int order[$];
      int k, idx;
      for (k = 0; k < current_size * current_size; k++) order.push_back(k);
      order.shuffle();
      for (k = 0; k < order.size(); k++) begin
         idx = order[k];
         send_request(idx / current_size, idx % current_size,
                      pick_cost(style == 4 ? $urandom_range(0, 3) : style),
                      k == order.size() - 1);
      end
   endtask

   initial begin
      int k;
      reset = 1;
      csr_write_enable = 0;
      csr_write_data = 0;
      req_chan.valid = 0;
      req_chan.row_index = 0;
      req_chan.column_index = 0;
      req_chan.entry_cost = 0;
      req_chan.last_entry = 0;
      entries_sent = 0;
      burst_left = 0;
      gap_left = 0;
      current_size = 16;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Size zero acts as size one; single extreme entries.
      write_size(0);
      send_request(0, 0, 16'h8000, 1'b1);
      send_request(0, 0, 16'h7FFF, 1'b1);
      write_size(2);
      send_request(0, 0, 16'h0001, 1'b0);
      send_request(0, 1, 16'h0005, 1'b0);
      send_request(1, 0, 16'h0005, 1'b0);
      send_request(1, 1, 16'hFFFF, 1'b1);
      // Ties everywhere: all equal costs.
      send_request(0, 0, 16'h0003, 1'b0);
      send_request(0, 1, 16'h0003, 1'b0);
      send_request(1, 0, 16'h0003, 1'b0);
      send_request(1, 1, 16'h0003, 1'b1);
      // Out-of-range rows and columns are ignored by the 2x2 solve; last still solves.
      send_request(15, 15, 16'hAAAA, 1'b0);
      send_request(9, 3, 16'h5555, 1'b1);
      // One full-size matrix fills the whole store.
      write_size(16);
      load_matrix(1);
      // Size above the maximum saturates to sixteen.
      write_size(31);
      send_request(15, 0, 16'h7FFF, 1'b1);

      // Random part: small sizes with mixed cost styles.
      while (entries_sent < 370) begin
         write_size($urandom_range(1, 6));
         load_matrix($urandom_range(0, 4));
      end
      drain_results();
      done = 1;
   end

   initial begin
      done = 0;
      wait (done);
      $display("Sent %0d cost entries and checked %0d solves at sizes one to sixteen,",
               entries_sent, solve_count);
      $display("with extreme, tied and random costs under sender gaps and receiver stalls.");
      if (failure_count == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #50ms;
      $display("CHECKS FAILED");
      $finish;
   end
endmodule
